// File: sv/ipv4hrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4hrc_pkg
// Shared types, widths and status codes for the IPv4 header receive check.
// ----------------------------------------------------------------------------
package ipv4hrc_pkg;

    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned SUM_W     = 17;
    localparam int unsigned HDR_W     = 6;
    localparam int unsigned STATUS_W  = 3;
    localparam int unsigned OUT_DATA_W = 32;

    localparam logic [ADDR_W-1:0]  BCAST_ADDR   = 32'hffff_ffff;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 16'hffff;
    localparam logic [3:0]         IP_VERSION   = 4'd4;
    localparam logic [3:0]         IHL_MIN      = 4'd5;
    localparam logic [COUNT_W-1:0] TTL_POS      = 16'd8;
    localparam logic [COUNT_W-1:0] DEST_FIRST   = 16'd16;
    localparam logic [COUNT_W-1:0] DEST_LAST    = 16'd19;

    // Verdict codes, in check order after the short-packet case
    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPT   = 3'd0,
        ST_CHECKSUM = 3'd1,
        ST_VERSION  = 3'd2,
        ST_HDR_LEN  = 3'd3,
        ST_TTL      = 3'd4,
        ST_DEST     = 3'd5
    } status_t;

    // One verdict, as handed from the check core to the output register
    typedef struct packed {
        logic [COUNT_W-1:0] payload_length;
        logic [HDR_W-1:0]   header_bytes;
        status_t            status;
    } result_t;

endpackage

// File: sv/ipv4hrc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4hrc_core
// Per-packet header state: field capture, running ones'-complement sum and
// the final verdict, one byte per step.
// ----------------------------------------------------------------------------
module ipv4hrc_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               step,
    input  logic [ipv4hrc_pkg::BYTE_W-1:0]     data_byte,
    input  logic                               last_byte,
    input  logic [ipv4hrc_pkg::ADDR_W-1:0]     local_address,
    output ipv4hrc_pkg::result_t               result
);

    logic [ipv4hrc_pkg::COUNT_W-1:0] byte_count_reg,  byte_count_next;
    logic [ipv4hrc_pkg::SUM_W-1:0]   sum_acc_reg,     sum_acc_next;
    logic [ipv4hrc_pkg::BYTE_W-1:0]  high_half_reg,   high_half_next;
    logic [ipv4hrc_pkg::BYTE_W-1:0]  version_ihl_reg, version_ihl_next;
    logic [ipv4hrc_pkg::BYTE_W-1:0]  ttl_value_reg,   ttl_value_next;
    logic [ipv4hrc_pkg::ADDR_W-1:0]  dest_addr_reg,   dest_addr_next;

    logic [ipv4hrc_pkg::BYTE_W-1:0]  vi;
    logic [ipv4hrc_pkg::HDR_W-1:0]   hb;
    logic [ipv4hrc_pkg::COUNT_W-1:0] hb_ext;
    logic                            in_hdr;
    logic [ipv4hrc_pkg::SUM_W:0]     sum_add;
    logic [ipv4hrc_pkg::SUM_W-1:0]   sum_fold;
    logic [ipv4hrc_pkg::SUM_W-1:0]   sum_upd;
    logic [ipv4hrc_pkg::SUM_W-1:0]   sum_final;
    logic [ipv4hrc_pkg::BYTE_W-1:0]  ttl_upd;
    logic [ipv4hrc_pkg::ADDR_W-1:0]  dest_upd;
    logic [ipv4hrc_pkg::COUNT_W-1:0] total;

    // Header length follows the current byte when it is byte 0
    always_comb
    begin
        vi     = (byte_count_reg == '0) ? data_byte : version_ihl_reg;
        hb     = {vi[3:0], 2'b00};
        hb_ext = {{(ipv4hrc_pkg::COUNT_W-ipv4hrc_pkg::HDR_W){1'b0}}, hb};
        in_hdr = (byte_count_reg < hb_ext);
    end

    // Ones'-complement word add with end-around carry
    always_comb
    begin
        sum_add  = {1'b0, sum_acc_reg} + {2'b00, high_half_reg, data_byte};
        sum_fold = {1'b0, sum_add[15:0]} + {15'd0, sum_add[17:16]};
        sum_upd  = (in_hdr && byte_count_reg[0]) ? sum_fold : sum_acc_reg;
        sum_final = {1'b0, sum_upd[15:0]} + {16'd0, sum_upd[16]};
    end

    // Field capture by byte position
    always_comb
    begin
        ttl_upd  = (byte_count_reg == ipv4hrc_pkg::TTL_POS) ? data_byte : ttl_value_reg;
        dest_upd = dest_addr_reg;
        if (byte_count_reg >= ipv4hrc_pkg::DEST_FIRST
            && byte_count_reg <= ipv4hrc_pkg::DEST_LAST)
        begin
            dest_upd = {dest_addr_reg[23:0], data_byte};
        end
        total = (byte_count_reg != ipv4hrc_pkg::COUNT_MAX) ? byte_count_reg + 16'd1
                                                           : ipv4hrc_pkg::COUNT_MAX;
    end

    // Verdict, valid on the last byte
    always_comb
    begin
        if (total < hb_ext)
            result.status = ipv4hrc_pkg::ST_HDR_LEN;
        else if (sum_final != 17'h0ffff)
            result.status = ipv4hrc_pkg::ST_CHECKSUM;
        else if (vi[7:4] != ipv4hrc_pkg::IP_VERSION)
            result.status = ipv4hrc_pkg::ST_VERSION;
        else if (vi[3:0] < ipv4hrc_pkg::IHL_MIN)
            result.status = ipv4hrc_pkg::ST_HDR_LEN;
        else if (ttl_upd == '0)
            result.status = ipv4hrc_pkg::ST_TTL;
        else if (dest_upd != local_address && dest_upd != ipv4hrc_pkg::BCAST_ADDR)
            result.status = ipv4hrc_pkg::ST_DEST;
        else
            result.status = ipv4hrc_pkg::ST_ACCEPT;
        result.header_bytes   = hb;
        result.payload_length = (total > hb_ext) ? total - hb_ext : '0;
    end

    // Next state: advance on a beat, clear after the last byte
    always_comb
    begin
        byte_count_next  = byte_count_reg;
        sum_acc_next     = sum_acc_reg;
        high_half_next   = high_half_reg;
        version_ihl_next = version_ihl_reg;
        ttl_value_next   = ttl_value_reg;
        dest_addr_next   = dest_addr_reg;
        if (step)
        begin
            if (last_byte)
            begin
                byte_count_next  = '0;
                sum_acc_next     = '0;
                high_half_next   = '0;
                version_ihl_next = '0;
                ttl_value_next   = '0;
                dest_addr_next   = '0;
            end
            else
            begin
                byte_count_next  = total;
                sum_acc_next     = sum_upd;
                high_half_next   = (in_hdr && !byte_count_reg[0]) ? data_byte
                                                                  : high_half_reg;
                version_ihl_next = vi;
                ttl_value_next   = ttl_upd;
                dest_addr_next   = dest_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            sum_acc_reg     <= '0;
            high_half_reg   <= '0;
            version_ihl_reg <= '0;
            ttl_value_reg   <= '0;
            dest_addr_reg   <= '0;
        end
        else
        begin
            byte_count_reg  <= byte_count_next;
            sum_acc_reg     <= sum_acc_next;
            high_half_reg   <= high_half_next;
            version_ihl_reg <= version_ihl_next;
            ttl_value_reg   <= ttl_value_next;
            dest_addr_reg   <= dest_addr_next;
        end
    end

endmodule

// File: sv/ipv4_header_receive_check_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_header_receive_check_unit
// Byte-stream IPv4 header check: checksum, version, IHL, TTL, destination.
// ----------------------------------------------------------------------------
// Takes packet bytes on the slave stream (tlast on the final byte) and returns
// one verdict beat per packet on the master stream. Bytes pass an input
// register and one step of header state update; the verdict is loaded into
// an output register as the last byte leaves the input register. Throughput
// is one byte per cycle, set by the single state-update step, unless stalled;
// input ready drops only while a verdict waits in the output register and
// the byte in the input register is a packet's last. Write local_address
// through cfg_we/cfg_wdata only while no packet is in flight.
module ipv4_header_receive_check_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: local_address
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    // byte stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    // verdict stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [2:0] status, [8:3] header_bytes,
                                        // [24:9] payload_length, [31:25] zero
);

    logic [ipv4hrc_pkg::ADDR_W-1:0] local_address_reg;

    logic                           in_valid_reg;
    logic [ipv4hrc_pkg::BYTE_W-1:0] in_byte_reg;
    logic                           in_last_reg;

    logic                           out_valid_reg;
    ipv4hrc_pkg::result_t           out_result_reg;

    logic                           out_free;
    logic                           advance;
    ipv4hrc_pkg::result_t           result;

    // Local address register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            local_address_reg <= '0;
        else if (cfg_we)
            local_address_reg <= cfg_wdata;
    end

    // Handshake: a non-last byte never needs output space
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    ipv4hrc_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .data_byte     (in_byte_reg),
        .last_byte     (in_last_reg),
        .local_address (local_address_reg),
        .result        (result)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
            out_result_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_result_reg};

endmodule
